// File: rtl/sphere_box_contact_defines.svh
// Assertion macros shared by the sphere and box contact RTL.
`ifndef SPHERE_BOX_CONTACT_DEFINES_SVH
`define SPHERE_BOX_CONTACT_DEFINES_SVH

// Condition implies property in the same cycle.
`define SBC_ASSERT_IMPL(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Condition implies property in the next cycle.
`define SBC_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/sbc_pkg.sv
// Shared constants and a rounding helper function for the sphere and box contact block.
package sbc_pkg;

  localparam int SIZE_BITS   = 20;
  localparam int QUAT_BITS   = 16;
  localparam int DEPTH_BITS  = 21;
  localparam int NZ_BITS     = 24;
  localparam int GAP_BITS    = 20;
  localparam int SQ_BITS     = 42;
  localparam int LEN_BITS    = 22;
  localparam int SQRT_STEPS  = 21;
  localparam int PT_BITS     = 23;
  localparam int LEAST_BITS  = 23;

  // Divide by 2^s, rounding to nearest with ties away from zero.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

// File: rtl/sbc_if.sv
// Channel interfaces: pair input, contact output and configuration write.
interface sbc_pair_if #(parameter int POSITION_BITS = 24);
  logic                                   valid;
  logic                                   ready;
  logic signed [POSITION_BITS-1:0]        sphere_x;
  logic signed [POSITION_BITS-1:0]        sphere_y;
  logic signed [POSITION_BITS-1:0]        sphere_z;
  logic [sbc_pkg::SIZE_BITS-1:0]          sphere_radius;
  logic signed [POSITION_BITS-1:0]        box_x;
  logic signed [POSITION_BITS-1:0]        box_y;
  logic signed [POSITION_BITS-1:0]        box_z;
  logic signed [sbc_pkg::QUAT_BITS-1:0]   rot_w;
  logic signed [sbc_pkg::QUAT_BITS-1:0]   rot_x;
  logic signed [sbc_pkg::QUAT_BITS-1:0]   rot_y;
  logic signed [sbc_pkg::QUAT_BITS-1:0]   rot_z;
  logic [3*sbc_pkg::SIZE_BITS-1:0]        box_half_extents;
  modport source(output valid, sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y,
                 box_z, rot_w, rot_x, rot_y, rot_z, box_half_extents, input ready);
  modport sink(input valid, sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y,
               box_z, rot_w, rot_x, rot_y, rot_z, box_half_extents, output ready);
endinterface

interface sbc_contact_if #(parameter int POSITION_BITS = 24);
  logic                                   valid;
  logic                                   ready;
  logic                                   hit;
  logic signed [sbc_pkg::QUAT_BITS-1:0]   normal_x;
  logic signed [sbc_pkg::QUAT_BITS-1:0]   normal_y;
  logic signed [sbc_pkg::QUAT_BITS-1:0]   normal_z;
  logic signed [POSITION_BITS-1:0]        contact_x;
  logic signed [POSITION_BITS-1:0]        contact_y;
  logic signed [POSITION_BITS-1:0]        contact_z;
  logic [sbc_pkg::DEPTH_BITS-1:0]         depth;
  modport source(output valid, hit, normal_x, normal_y, normal_z, contact_x, contact_y,
                 contact_z, depth, input ready);
  modport sink(input valid, hit, normal_x, normal_y, normal_z, contact_x, contact_y,
               contact_z, depth, output ready);
endinterface

interface sbc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sbc_pkg::NZ_BITS-1:0]     near_zero_squared;
  modport source(output valid, near_zero_squared, input ready);
  modport sink(input valid, near_zero_squared, output ready);
endinterface

// File: rtl/sbc_norm.sv
// Pipelined square root of the squared gap and three restoring normal dividers.
`include "sphere_box_contact_defines.svh"

module sbc_norm #(
  parameter int FRAC   = 14,
  parameter int SIDE_W = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [sbc_pkg::SQ_BITS-1:0]             squared,
  input  logic [2:0][sbc_pkg::GAP_BITS-1:0]       gabs,
  input  logic [SIDE_W-1:0]                       side,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [sbc_pkg::LEN_BITS-1:0]            len,
  output logic [2:0][FRAC+1:0]                    quo,
  output logic [SIDE_W-1:0]                       out_side
);

  localparam int SQS = sbc_pkg::SQRT_STEPS;
  localparam int LB  = sbc_pkg::LEN_BITS;
  localparam int XW  = sbc_pkg::SQ_BITS + 1;
  localparam int CW  = LB + FRAC + 2;
  localparam int NS  = SQS + 1 + FRAC + 2;

  typedef struct packed {
    logic [XW-1:0]                         x;
    logic [XW-1:0]                         res;
    logic [2:0][sbc_pkg::GAP_BITS-1:0]     ga;
    logic [2:0][CW-1:0]                    rem;
    logic [2:0][FRAC+1:0]                  q;
    logic [LB-1:0]                         len;
    logic [SIDE_W-1:0]                     side;
  } stage_t;

  stage_t       st   [NS];
  stage_t       prv  [NS];
  stage_t       nxt  [NS];
  logic [NS-1:0] v;
  logic [NS-1:0] prv_v;
  logic [NS:0]   adv;

  assign adv[NS]   = out_ready;
  assign in_ready  = adv[0];
  assign out_valid = v[NS-1];
  assign len       = st[NS-1].len;
  assign quo       = st[NS-1].q;
  assign out_side  = st[NS-1].side;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_comb begin
        prv[k]      = '0;
        prv[k].x    = XW'(squared);
        prv[k].ga   = gabs;
        prv[k].side = side;
        prv_v[k]    = in_valid;
      end
    end else begin : g_rest
      assign prv[k]   = st[k-1];
      assign prv_v[k] = v[k-1];
    end

    if (k < SQS) begin : g_sqrt
      // One result bit of the square root per stage.
      localparam logic [XW-1:0] BIT = XW'(1) << (2 * (SQS - 1 - k));
      always_comb begin
        nxt[k] = prv[k];
        if (prv[k].x >= prv[k].res + BIT) begin
          nxt[k].x   = prv[k].x - (prv[k].res + BIT);
          nxt[k].res = (prv[k].res >> 1) + BIT;
        end else begin
          nxt[k].res = prv[k].res >> 1;
        end
      end
    end else if (k == SQS) begin : g_round
      logic [XW-1:0] rr;
      always_comb begin
        nxt[k] = prv[k];
        rr = prv[k].res + XW'(prv[k].x > prv[k].res);
        nxt[k].len = LB'(rr);
        for (int i = 0; i < 3; i++) begin
          nxt[k].rem[i] = (CW'(prv[k].ga[i]) << FRAC) + CW'(rr[LB-1:1]);
        end
      end
    end else begin : g_div
      // Quotient bit SH of all three dividers.
      localparam int SH = FRAC + 1 - (k - SQS - 1);
      logic [CW-1:0] dv;
      always_comb begin
        nxt[k] = prv[k];
        dv = CW'(prv[k].len) << SH;
        for (int i = 0; i < 3; i++) begin
          if (prv[k].rem[i] >= dv) begin
            nxt[k].rem[i]   = prv[k].rem[i] - dv;
            nxt[k].q[i][SH] = 1'b1;
          end
        end
      end
    end

    assign adv[k] = !v[k] || adv[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv[k]) begin
        v[k] <= prv_v[k];
      end
      if (adv[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  `SBC_ASSERT_NEXT(a_norm_load, in_valid && in_ready, v[0], "accepted word did not enter the root pipeline")
  `SBC_ASSERT_IMPL(a_root_bound, v[SQS-1], (st[SQS-1].res >> SQS) == '0, "square root exceeds its range")
  `SBC_ASSERT_IMPL(a_len_bound, v[SQS], st[SQS].len <= (LB'(1) << (SQS)), "rounded length exceeds its range")

endmodule

// File: rtl/sphere_box_contact.sv
// Sphere versus oriented box contact: one pair per cycle unless stalled, fully pipelined.
// Throughput: one pair per cycle while the output is not stalled; the square root (one bit per
// stage) and the normal dividers (one quotient bit per stage) set the pipeline depth.
// Reset: synchronous rst empties every stage and sets near_zero_squared to 1.
`include "sphere_box_contact_defines.svh"

module sphere_box_contact #(
  parameter int POSITION_BITS      = 24,
  parameter int ROTATION_FRAC_BITS = 14
) (
  input  logic           clk,
  input  logic           rst,
  sbc_pair_if.sink       pair,
  sbc_contact_if.source  contact,
  sbc_cfg_if.sink        cfg
);

  localparam int P    = POSITION_BITS;
  localparam int F    = ROTATION_FRAC_BITS;
  localparam int SB   = sbc_pkg::SIZE_BITS;
  localparam int QB   = sbc_pkg::QUAT_BITS;
  localparam int GB   = sbc_pkg::GAP_BITS;
  localparam int LB   = sbc_pkg::LEN_BITS;
  localparam int DB   = sbc_pkg::DEPTH_BITS;
  localparam int PTW  = sbc_pkg::PT_BITS;
  localparam int LSW  = sbc_pkg::LEAST_BITS;
  localparam int DW   = P + 1;
  localparam int QPW  = 2 * QB;
  localparam int RAWW = ((2 * F > 32) ? 2 * F : 32) + 3;
  localparam int ROTW = RAWW - F + 1;
  localparam int PRW  = ROTW + DW;
  localparam int LOCW = PRW + 2 - F + 1;
  localparam int NLW  = F + 3;
  localparam int NPW  = ROTW + NLW;
  localparam int CPW  = ROTW + PTW;
  localparam int DPW  = LB + 2;

  typedef struct packed {
    logic [8:0][ROTW-1:0]  rot;
    logic [2:0][P-1:0]     bp;
    logic [2:0][PTW-1:0]   pt;
    logic [2:0]            gneg;
    logic [SB-1:0]         r;
    logic [LSW-1:0]        least;
    logic [1:0]            axis;
    logic                  sgn;
    logic                  miss;
    logic                  in_box;
  } tail_t;

  // Configuration register.
  logic [sbc_pkg::NZ_BITS-1:0] nz;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      nz <= sbc_pkg::NZ_BITS'(1);
    end else if (cfg.valid) begin
      nz <= cfg.near_zero_squared;
    end
  end

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic en1, en2, en3, en4, en5, en6, en7, en8, en9;
  logic n_in_ready, n_out_valid;

  assign en9 = !v9 || contact.ready;
  assign en8 = !v8 || en9;
  assign en7 = !v7 || n_in_ready;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pair.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
    end else begin
      if (en1) v1 <= pair.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
      if (en8) v8 <= n_out_valid;
      if (en9) v9 <= v8;
    end
  end

  // Stage 1: offsets and quaternion products.
  logic signed [DW-1:0]  d1 [3];
  logic signed [QPW-1:0] qp1 [9];
  logic signed [P-1:0]   bp1 [3];
  logic [SB-1:0]         h1 [3];
  logic [SB-1:0]         r1;

  always_ff @(posedge clk) begin
    if (en1) begin
      d1[0]  <= DW'(pair.sphere_x) - DW'(pair.box_x);
      d1[1]  <= DW'(pair.sphere_y) - DW'(pair.box_y);
      d1[2]  <= DW'(pair.sphere_z) - DW'(pair.box_z);
      qp1[0] <= pair.rot_x * pair.rot_x;
      qp1[1] <= pair.rot_y * pair.rot_y;
      qp1[2] <= pair.rot_z * pair.rot_z;
      qp1[3] <= pair.rot_x * pair.rot_y;
      qp1[4] <= pair.rot_x * pair.rot_z;
      qp1[5] <= pair.rot_y * pair.rot_z;
      qp1[6] <= pair.rot_w * pair.rot_x;
      qp1[7] <= pair.rot_w * pair.rot_y;
      qp1[8] <= pair.rot_w * pair.rot_z;
      bp1[0] <= pair.box_x;
      bp1[1] <= pair.box_y;
      bp1[2] <= pair.box_z;
      h1[0]  <= pair.box_half_extents[SB-1:0];
      h1[1]  <= pair.box_half_extents[2*SB-1:SB];
      h1[2]  <= pair.box_half_extents[3*SB-1:2*SB];
      r1     <= pair.sphere_radius;
    end
  end

  // Stage 2: rotation matrix, rounded to F fraction bits.
  logic signed [63:0]    raw [9];
  logic signed [63:0]    qx [9];
  logic signed [63:0]    one_c;
  logic signed [ROTW-1:0] rot2 [9];
  logic signed [DW-1:0]  d2 [3];
  logic signed [P-1:0]   bp2 [3];
  logic [SB-1:0]         h2 [3];
  logic [SB-1:0]         r2;

  always_comb begin
    one_c = 64'sd1 <<< (2 * F);
    for (int i = 0; i < 9; i++) qx[i] = 64'(qp1[i]);
    raw[0] = one_c - 64'sd2 * (qx[1] + qx[2]);
    raw[1] = 64'sd2 * (qx[3] - qx[8]);
    raw[2] = 64'sd2 * (qx[4] + qx[7]);
    raw[3] = 64'sd2 * (qx[3] + qx[8]);
    raw[4] = one_c - 64'sd2 * (qx[0] + qx[2]);
    raw[5] = 64'sd2 * (qx[5] - qx[6]);
    raw[6] = 64'sd2 * (qx[4] - qx[7]);
    raw[7] = 64'sd2 * (qx[5] + qx[6]);
    raw[8] = one_c - 64'sd2 * (qx[0] + qx[1]);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 9; i++) rot2[i] <= ROTW'(sbc_pkg::round_shift(raw[i], F));
      d2  <= d1;
      bp2 <= bp1;
      h2  <= h1;
      r2  <= r1;
    end
  end

  // Stage 3: products of the transposed matrix with the offset.
  logic signed [PRW-1:0]  pr3 [3][3];
  logic signed [ROTW-1:0] rot3 [9];
  logic signed [P-1:0]    bp3 [3];
  logic [SB-1:0]          h3 [3];
  logic [SB-1:0]          r3;

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) pr3[i][j] <= rot2[3*j+i] * d2[j];
      rot3 <= rot2;
      bp3  <= bp2;
      h3   <= h2;
      r3   <= r2;
    end
  end

  // Stage 4: local sphere center.
  logic signed [LOCW-1:0] loc4 [3];
  logic signed [ROTW-1:0] rot4 [9];
  logic signed [P-1:0]    bp4 [3];
  logic [SB-1:0]          h4 [3];
  logic [SB-1:0]          r4;

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int i = 0; i < 3; i++)
        loc4[i] <= LOCW'(sbc_pkg::round_shift(64'(pr3[i][0]) + 64'(pr3[i][1]) +
                                              64'(pr3[i][2]), F));
      rot4 <= rot3;
      bp4  <= bp3;
      h4   <= h3;
      r4   <= r3;
    end
  end

  // Stage 5: clamp to the box and measure the gap per axis.
  logic signed [LOCW:0] hs [3];
  logic signed [LOCW:0] ls [3];
  logic signed [LOCW:0] cl [3];
  logic signed [LOCW:0] gp [3];
  logic signed [LOCW:0] ag [3];
  logic signed [LOCW:0] al [3];
  logic                 early_c;

  always_comb begin
    early_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      hs[i] = (LOCW+1)'({1'b0, h4[i]});
      ls[i] = (LOCW+1)'(loc4[i]);
      if (ls[i] < -hs[i]) cl[i] = -hs[i];
      else if (ls[i] > hs[i]) cl[i] = hs[i];
      else cl[i] = ls[i];
      gp[i] = ls[i] - cl[i];
      ag[i] = gp[i][LOCW] ? -gp[i] : gp[i];
      al[i] = ls[i][LOCW] ? -ls[i] : ls[i];
      if (ag[i] > (LOCW+1)'({1'b0, r4})) early_c = 1'b1;
    end
  end

  logic signed [LOCW:0]   g5 [3];
  logic [GB-1:0]          ga5 [3];
  logic [2:0]             gneg5;
  logic [2:0]             lneg5;
  logic signed [PTW-1:0]  pout5 [3];
  logic signed [PTW-1:0]  pin5 [3];
  logic                   early5;
  logic signed [ROTW-1:0] rot5 [9];
  logic signed [P-1:0]    bp5 [3];
  logic [SB-1:0]          h5 [3];
  logic [SB-1:0]          r5;

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int i = 0; i < 3; i++) begin
        g5[i]    <= hs[i] - al[i];
        ga5[i]   <= ag[i][GB-1:0];
        gneg5[i] <= gp[i][LOCW];
        lneg5[i] <= ls[i][LOCW];
        pout5[i] <= PTW'(cl[i]);
        pin5[i]  <= PTW'(ls[i]);
      end
      early5 <= early_c;
      rot5   <= rot4;
      bp5    <= bp4;
      h5     <= h4;
      r5     <= r4;
    end
  end

  // Stage 6: squared gaps, nearest face for the inside case.
  logic signed [LOCW:0]   least_c;
  logic [1:0]             axis_c;
  logic signed [PTW-1:0]  pin_c [3];
  logic signed [PTW-1:0]  hax;

  always_comb begin
    least_c = g5[0];
    axis_c  = 2'd0;
    if (g5[1] < least_c) begin
      least_c = g5[1];
      axis_c  = 2'd1;
    end
    if (g5[2] < least_c) begin
      least_c = g5[2];
      axis_c  = 2'd2;
    end
    hax = PTW'({1'b0, h5[axis_c]});
    pin_c = pin5;
    pin_c[axis_c] = lneg5[axis_c] ? -hax : hax;
  end

  logic [2*GB-1:0]        sq6 [3];
  logic [2*SB-1:0]        rr6;
  logic [GB-1:0]          ga6 [3];
  logic [2:0]             gneg6;
  logic signed [PTW-1:0]  pout6 [3];
  logic signed [PTW-1:0]  pin6 [3];
  logic signed [LSW-1:0]  least6;
  logic [1:0]             axis6;
  logic                   sgn6;
  logic                   early6;
  logic signed [ROTW-1:0] rot6 [9];
  logic signed [P-1:0]    bp6 [3];
  logic [SB-1:0]          r6;

  always_ff @(posedge clk) begin
    if (en6) begin
      for (int i = 0; i < 3; i++) sq6[i] <= ga5[i] * ga5[i];
      rr6    <= r5 * r5;
      ga6    <= ga5;
      gneg6  <= gneg5;
      pout6  <= pout5;
      pin6   <= pin_c;
      least6 <= LSW'(least_c);
      axis6  <= axis_c;
      sgn6   <= lneg5[axis_c];
      early6 <= early5;
      rot6   <= rot5;
      bp6    <= bp5;
      r6     <= r5;
    end
  end

  // Stage 7: total squared gap, miss and inside decisions.
  logic [sbc_pkg::SQ_BITS-1:0] sq_c;
  logic                        in_box_c;
  tail_t                       tail_c;

  always_comb begin
    sq_c = sbc_pkg::SQ_BITS'(sq6[0]) + sbc_pkg::SQ_BITS'(sq6[1]) +
           sbc_pkg::SQ_BITS'(sq6[2]);
    in_box_c = sq_c <= sbc_pkg::SQ_BITS'(nz);
    tail_c = '0;
    for (int i = 0; i < 9; i++) tail_c.rot[i] = rot6[i];
    for (int i = 0; i < 3; i++) begin
      tail_c.bp[i]   = bp6[i];
      tail_c.pt[i]   = in_box_c ? pin6[i] : pout6[i];
      tail_c.gneg[i] = gneg6[i];
    end
    tail_c.r      = r6;
    tail_c.least  = least6;
    tail_c.axis   = axis6;
    tail_c.sgn    = sgn6;
    tail_c.miss   = early6 || (sq_c > sbc_pkg::SQ_BITS'(rr6));
    tail_c.in_box = in_box_c;
  end

  logic [sbc_pkg::SQ_BITS-1:0] sq7;
  logic [2:0][GB-1:0]          ga7;
  tail_t                       tail7;

  always_ff @(posedge clk) begin
    if (en7) begin
      sq7   <= sq_c;
      for (int i = 0; i < 3; i++) ga7[i] <= ga6[i];
      tail7 <= tail_c;
    end
  end

  logic [LB-1:0]         n_len;
  logic [2:0][F+1:0]     n_quo;
  logic [$bits(tail_t)-1:0] n_side;

  sbc_norm #(
    .FRAC   (F),
    .SIDE_W ($bits(tail_t))
  ) u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .in_ready  (n_in_ready),
    .squared   (sq7),
    .gabs      (ga7),
    .side      (tail7),
    .out_valid (n_out_valid),
    .out_ready (en8),
    .len       (n_len),
    .quo       (n_quo),
    .out_side  (n_side)
  );

  // Stage 8: products for world normal and contact point, and the depth.
  tail_t                  tn;
  logic signed [NLW-1:0]  nl [3];
  logic signed [ROTW-1:0] col [3];

  always_comb begin
    tn = tail_t'(n_side);
    for (int j = 0; j < 3; j++) begin
      nl[j] = tn.gneg[j] ? -$signed({1'b0, n_quo[j]}) : $signed({1'b0, n_quo[j]});
    end
    for (int i = 0; i < 3; i++) begin
      unique case (tn.axis)
        2'd0:    col[i] = $signed(tn.rot[3*i]);
        2'd1:    col[i] = $signed(tn.rot[3*i+1]);
        default: col[i] = $signed(tn.rot[3*i+2]);
      endcase
    end
  end

  logic signed [NPW-1:0]  npr8 [3][3];
  logic signed [CPW-1:0]  cpr8 [3][3];
  logic signed [ROTW:0]   nin8 [3];
  logic signed [DPW-1:0]  dep8;
  logic signed [P-1:0]    bp8 [3];
  logic                   miss8;
  logic                   in_box8;

  always_ff @(posedge clk) begin
    if (en8) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          npr8[i][j] <= $signed(tn.rot[3*i+j]) * nl[j];
          cpr8[i][j] <= $signed(tn.rot[3*i+j]) * $signed(tn.pt[j]);
        end
        nin8[i] <= tn.sgn ? -(ROTW+1)'(col[i]) : (ROTW+1)'(col[i]);
        bp8[i]  <= $signed(tn.bp[i]);
      end
      if (tn.in_box) dep8 <= DPW'({1'b0, tn.r}) + DPW'($signed(tn.least));
      else dep8 <= DPW'({1'b0, tn.r}) - DPW'({1'b0, n_len});
      miss8   <= tn.miss;
      in_box8 <= tn.in_box;
    end
  end

  // Stage 9: sums, rounding, saturation; the output register.
  logic signed [63:0] unit_c;
  logic signed [63:0] pmax_c;
  logic signed [63:0] nacc [3];
  logic signed [63:0] nsel [3];
  logic signed [63:0] cacc [3];
  logic signed [63:0] dsat;
  logic signed [QB-1:0] nx_c [3];
  logic signed [P-1:0]  cx_c [3];

  always_comb begin
    unit_c = 64'sd1 <<< F;
    pmax_c = (64'sd1 <<< (P - 1)) - 64'sd1;
    for (int i = 0; i < 3; i++) begin
      nacc[i] = sbc_pkg::round_shift(64'(npr8[i][0]) + 64'(npr8[i][1]) +
                                     64'(npr8[i][2]), F);
      nsel[i] = in_box8 ? 64'(nin8[i]) : nacc[i];
      if (nsel[i] > unit_c) nsel[i] = unit_c;
      else if (nsel[i] < -unit_c) nsel[i] = -unit_c;
      cacc[i] = 64'(bp8[i]) + sbc_pkg::round_shift(64'(cpr8[i][0]) + 64'(cpr8[i][1]) +
                                                   64'(cpr8[i][2]), F);
      if (cacc[i] > pmax_c) cacc[i] = pmax_c;
      else if (cacc[i] < -pmax_c - 64'sd1) cacc[i] = -pmax_c - 64'sd1;
      nx_c[i] = miss8 ? '0 : QB'(nsel[i]);
      cx_c[i] = miss8 ? '0 : P'(cacc[i]);
    end
    dsat = 64'(dep8);
    if (dsat < 64'sd0) dsat = 64'sd0;
    else if (dsat > (64'sd1 <<< DB) - 64'sd1) dsat = (64'sd1 <<< DB) - 64'sd1;
    if (miss8) dsat = 64'sd0;
  end

  logic                 hit9;
  logic signed [QB-1:0] nx9 [3];
  logic signed [P-1:0]  cx9 [3];
  logic [DB-1:0]        dep9;

  always_ff @(posedge clk) begin
    if (en9) begin
      hit9 <= !miss8;
      nx9  <= nx_c;
      cx9  <= cx_c;
      dep9 <= DB'(dsat);
    end
  end

  assign contact.valid     = v9;
  assign contact.hit       = hit9;
  assign contact.normal_x  = nx9[0];
  assign contact.normal_y  = nx9[1];
  assign contact.normal_z  = nx9[2];
  assign contact.contact_x = cx9[0];
  assign contact.contact_y = cx9[1];
  assign contact.contact_z = cx9[2];
  assign contact.depth     = dep9;

  `SBC_ASSERT_IMPL(a_miss_zero, contact.valid && !contact.hit, contact.depth == '0 && contact.normal_x == '0 && contact.contact_x == '0, "miss word carries nonzero fields")
  `SBC_ASSERT_IMPL(a_entry_ready, !v1, pair.ready, "empty entry stage refuses a pair")
  `SBC_ASSERT_NEXT(a_out_hold, contact.valid && !contact.ready, contact.valid, "stalled contact word was dropped")

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the sphere versus oriented box contact block.
`timescale 1ns / 1ps

module tb_top;

  localparam int PB = 24;
  localparam int FB = 14;
  localparam int SB = sbc_pkg::SIZE_BITS;
  localparam int QB = sbc_pkg::QUAT_BITS;
  localparam int DB = sbc_pkg::DEPTH_BITS;
  localparam int NZB = sbc_pkg::NZ_BITS;
  localparam int LATENCY = FB + 33;
  localparam int NUM_RANDOM = 1130;

  typedef struct {
    logic signed [PB-1:0] sx, sy, sz;
    logic [SB-1:0] rad;
    logic signed [PB-1:0] bx, by, bz;
    logic signed [QB-1:0] qw, qx, qy, qz;
    logic [3*SB-1:0] half;
  } pair_t;

  typedef struct {
    logic hit;
    logic signed [QB-1:0] nx, ny, nz;
    logic signed [PB-1:0] cx, cy, cz;
    logic [DB-1:0] depth;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sbc_pair_if #(.POSITION_BITS(PB)) pair_ch();
  sbc_contact_if #(.POSITION_BITS(PB)) contact_ch();
  sbc_cfg_if cfg_ch();

  sphere_box_contact #(.POSITION_BITS(PB), .ROTATION_FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .pair(pair_ch.sink), .contact(contact_ch.source), .cfg(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pair_t pending_pairs[$];
  contact_t expected_contacts[$];
  logic [NZB-1:0] inside_threshold = 1;
  int mismatches = 0;
  int contacts_seen = 0;
  int hits_seen = 0;
  int pairs_sent = 0;
  bit stall_long = 1'b0;

  function automatic longint rnd_shift(longint v, int s);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sqrt_nearest(longint x);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > x) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    if (x > res) res++;
    return res;
  endfunction

  // Works out the contact that one sphere and box pair should produce.
  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint sp[3], bp[3], h[3], d[3], loc[3], gap[3], pt[3], nl[3], nw[3];
    longint m[3][3];
    longint r, w, x, y, z, one, acc, sq, len, least, sgn, dep, q, g;
    longint pmax, pmin, unit;
    int ax;
    pmax = (64'sd1 <<< (PB - 1)) - 1;
    pmin = -(64'sd1 <<< (PB - 1));
    unit = 64'sd1 <<< FB;
    c = '{default: '0};
    sp[0] = p.sx; sp[1] = p.sy; sp[2] = p.sz;
    bp[0] = p.bx; bp[1] = p.by; bp[2] = p.bz;
    for (int i = 0; i < 3; i++) begin
      h[i] = longint'(p.half[SB*i +: SB]);
      d[i] = sp[i] - bp[i];
    end
    r = longint'(p.rad);
    w = p.qw; x = p.qx; y = p.qy; z = p.qz;
    one = 64'sd1 <<< (2 * FB);
    m[0][0] = one - 2 * (y * y + z * z);
    m[0][1] = 2 * (x * y - w * z);
    m[0][2] = 2 * (x * z + w * y);
    m[1][0] = 2 * (x * y + w * z);
    m[1][1] = one - 2 * (x * x + z * z);
    m[1][2] = 2 * (y * z - w * x);
    m[2][0] = 2 * (x * z - w * y);
    m[2][1] = 2 * (y * z + w * x);
    m[2][2] = one - 2 * (x * x + y * y);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = rnd_shift(m[i][j], FB);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += m[j][i] * d[j];
      loc[i] = rnd_shift(acc, FB);
      gap[i] = loc[i] - clip(loc[i], -h[i], h[i]);
      if (abs_l(gap[i]) > r) return c;
    end
    sq = gap[0] * gap[0] + gap[1] * gap[1] + gap[2] * gap[2];
    if (sq > r * r) return c;
    if (sq > longint'(inside_threshold)) begin
      len = sqrt_nearest(sq);
      for (int i = 0; i < 3; i++) begin
        q = ((abs_l(gap[i]) <<< FB) + len / 2) / len;
        nl[i] = gap[i] < 0 ? -q : q;
        pt[i] = loc[i] - gap[i];
      end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += m[i][j] * nl[j];
        nw[i] = clip(rnd_shift(acc, FB), -unit, unit);
      end
      dep = r - len;
    end else begin
      // Inside: leave through the nearest face, the lowest axis on a tie.
      ax = 0;
      least = h[0] - abs_l(loc[0]);
      for (int i = 1; i < 3; i++) begin
        g = h[i] - abs_l(loc[i]);
        if (g < least) begin
          least = g;
          ax = i;
        end
      end
      sgn = loc[ax] < 0 ? -1 : 1;
      for (int i = 0; i < 3; i++) begin
        pt[i] = loc[i];
        nw[i] = clip(sgn * m[i][ax], -unit, unit);
      end
      pt[ax] = sgn * h[ax];
      dep = r + least;
    end
    c.hit = 1'b1;
    c.nx = QB'(nw[0]); c.ny = QB'(nw[1]); c.nz = QB'(nw[2]);
    acc = 0;
    for (int j = 0; j < 3; j++) acc += m[0][j] * pt[j];
    c.cx = PB'(clip(bp[0] + rnd_shift(acc, FB), pmin, pmax));
    acc = 0;
    for (int j = 0; j < 3; j++) acc += m[1][j] * pt[j];
    c.cy = PB'(clip(bp[1] + rnd_shift(acc, FB), pmin, pmax));
    acc = 0;
    for (int j = 0; j < 3; j++) acc += m[2][j] * pt[j];
    c.cz = PB'(clip(bp[2] + rnd_shift(acc, FB), pmin, pmax));
    c.depth = DB'(clip(dep, 0, (64'sd1 <<< DB) - 1));
    return c;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      pair_ch.valid <= 1'b0;
    end else begin
      if (pair_ch.valid && pair_ch.ready) begin
        expected_contacts.push_back(predict_contact(pending_pairs.pop_front()));
        pairs_sent++;
      end
      if (pair_ch.valid && !pair_ch.ready) begin
        // Hold the offered word until it is taken.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        pair_ch.valid <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        // The head of the queue is the next word; an accepted one was popped above.
        pair_t p;
        p = pending_pairs[0];
        pair_ch.valid <= 1'b1;
        pair_ch.sphere_x <= p.sx; pair_ch.sphere_y <= p.sy; pair_ch.sphere_z <= p.sz;
        pair_ch.sphere_radius <= p.rad;
        pair_ch.box_x <= p.bx; pair_ch.box_y <= p.by; pair_ch.box_z <= p.bz;
        pair_ch.rot_w <= p.qw; pair_ch.rot_x <= p.qx;
        pair_ch.rot_y <= p.qy; pair_ch.rot_z <= p.qz;
        pair_ch.box_half_extents <= p.half;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        end
      end else begin
        pair_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls in one of four patterns picked at random, or for a long stretch on request.
  int stall_phase = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      contact_ch.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 200 == 0) stall_mode <= $urandom_range(0, 3);
      if (stall_long) contact_ch.ready <= 1'b0;
      else case (stall_mode)
        0: contact_ch.ready <= 1'b1;
        1: contact_ch.ready <= (stall_phase % 3) != 0;
        2: contact_ch.ready <= 1'($urandom_range(0, 1));
        default: contact_ch.ready <= (stall_phase % 16) < 4;
      endcase
    end
  end

  // Monitor: compares every accepted contact word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && contact_ch.valid && contact_ch.ready) begin
      contacts_seen++;
      if (contact_ch.hit) hits_seen++;
      if (expected_contacts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected contact word at %0t", $realtime);
      end else begin
        contact_t e;
        e = expected_contacts.pop_front();
        if (contact_ch.hit !== e.hit || contact_ch.normal_x !== e.nx ||
            contact_ch.normal_y !== e.ny || contact_ch.normal_z !== e.nz ||
            contact_ch.contact_x !== e.cx || contact_ch.contact_y !== e.cy ||
            contact_ch.contact_z !== e.cz || contact_ch.depth !== e.depth) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected hit %0d n (%0d %0d %0d) p (%0d %0d %0d) d %0d,",
                     $realtime, e.hit, e.nx, e.ny, e.nz, e.cx, e.cy, e.cz, e.depth,
                     "\n  got hit %0d n (%0d %0d %0d) p (%0d %0d %0d) d %0d",
                     contact_ch.hit, contact_ch.normal_x, contact_ch.normal_y,
                     contact_ch.normal_z, contact_ch.contact_x, contact_ch.contact_y,
                     contact_ch.contact_z, contact_ch.depth);
        end
      end
    end
  end

  function automatic pair_t random_pair(int style);
    pair_t p;
    logic [SB-1:0] hx, hy, hz;
    int s;
    p.qw = QB'($urandom); p.qx = QB'($urandom); p.qy = QB'($urandom);
    p.qz = QB'($urandom);
    case ($urandom_range(0, 4))
      0: begin p.qw = 16384; p.qx = 0; p.qy = 0; p.qz = 0; end
      1: begin // roughly unit: w and one other axis
        s = $urandom_range(0, 16384);
        p.qw = QB'(s); p.qx = 0; p.qy = 0; p.qz = 0;
        case ($urandom_range(0, 2))
          0: p.qx = QB'($urandom_range(0, 1) ? 16384 - s : s - 16384);
          1: p.qy = QB'(16384 - s);
          default: p.qz = QB'(s - 16384);
        endcase
      end
      2: begin p.qw = 11585; p.qx = -11585; p.qy = 0; p.qz = 0; end
      3: begin
        p.qw = QB'($signed(16'($urandom_range(0, 32768))) - 16384);
        p.qx = QB'($signed(16'($urandom_range(0, 32768))) - 16384);
        p.qy = QB'($signed(16'($urandom_range(0, 32768))) - 16384);
        p.qz = QB'($signed(16'($urandom_range(0, 32768))) - 16384);
      end
      default: begin p.qw = 8192; p.qx = 8192; p.qy = -8192; p.qz = 8192; end
    endcase
    if (style == 0) begin
      // Full range noise.
      p.sx = PB'($urandom); p.sy = PB'($urandom); p.sz = PB'($urandom);
      p.bx = PB'($urandom); p.by = PB'($urandom); p.bz = PB'($urandom);
      p.rad = SB'($urandom);
      p.half = (3*SB)'({$urandom, $urandom});
      if (p.qw < -16384) p.qw = -16384;
    end else begin
      // Sphere near the box so most pairs touch.
      s = (style == 1) ? 16 : 6;
      p.bx = $signed(24'($urandom)) >>> $urandom_range(0, 4);
      p.by = $signed(24'($urandom)) >>> $urandom_range(0, 4);
      p.bz = $signed(24'($urandom)) >>> $urandom_range(0, 4);
      hx = SB'($urandom_range(0, 1 << s)); hy = SB'($urandom_range(0, 1 << s));
      hz = SB'($urandom_range(0, 1 << s));
      if ($urandom_range(0, 9) == 0) hx = '1;
      p.half = {hz, hy, hx};
      p.rad = SB'($urandom_range(0, 1 << s));
      if ($urandom_range(0, 9) == 0) p.rad = '1;
      p.sx = PB'(p.bx + $signed(24'($urandom_range(0, 4 << s))) - (2 << s));
      p.sy = PB'(p.by + $signed(24'($urandom_range(0, 4 << s))) - (2 << s));
      p.sz = PB'(p.bz + $signed(24'($urandom_range(0, 4 << s))) - (2 << s));
    end
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || expected_contacts.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_threshold(logic [NZB-1:0] v);
    cfg_ch.near_zero_squared <= v;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    inside_threshold = v;
  endtask

  initial begin
    pair_t p;
    logic [NZB-1:0] settings[5];
    settings = '{0, 24'hFFFFFF, 4096, 24'd1, 24'h000400};
    cfg_ch.valid = 1'b0;
    cfg_ch.near_zero_squared = '0;
    pair_ch.valid = 1'b0;
    pair_ch.sphere_x = '0; pair_ch.sphere_y = '0; pair_ch.sphere_z = '0;
    pair_ch.sphere_radius = '0; pair_ch.box_x = '0; pair_ch.box_y = '0;
    pair_ch.box_z = '0; pair_ch.rot_w = '0; pair_ch.rot_x = '0; pair_ch.rot_y = '0;
    pair_ch.rot_z = '0; pair_ch.box_half_extents = '0;
    contact_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pairs: identity box, inside, tie, zero coordinate, extremes.
    p = '{sx: 0, sy: 0, sz: 0, rad: 4096, bx: 0, by: 0, bz: 0,
          qw: 16384, qx: 0, qy: 0, qz: 0, half: {20'd4096, 20'd4096, 20'd4096}};
    pending_pairs.push_back(p);
    p.sx = 100; p.sz = -2000; pending_pairs.push_back(p);
    p.sx = 6000; p.sz = 0; pending_pairs.push_back(p);
    p.sx = 20000; pending_pairs.push_back(p);
    p.sx = 6000; p.sy = -6000; p.sz = 6000; pending_pairs.push_back(p);
    p.sx = 8388607; p.sy = 8388607; p.sz = 8388607;
    p.bx = 8388607; p.by = 8388607; p.bz = 8388607; p.rad = '1;
    p.half = '1; pending_pairs.push_back(p);
    p.sx = -8388608; p.sy = -8388608; p.sz = -8388608;
    p.bx = 8388607; p.by = 8388607; p.bz = 8388607; pending_pairs.push_back(p);
    p.bx = -8388608; p.by = -8388608; p.bz = -8388608; p.sx = -8388608;
    p.sy = -8388608; p.sz = -8388608; p.qw = -16384; pending_pairs.push_back(p);
    p.qw = 16384; p.qx = 16384; p.qy = 16384; p.qz = 16384; p.half = 0; p.rad = 0;
    pending_pairs.push_back(p);
    p.qw = -16384; p.qx = -16384; p.qy = -16384; p.qz = -16384; p.rad = 100;
    p.sx = p.bx + 50; pending_pairs.push_back(p);
    p.qw = 0; p.qx = 0; p.qy = 0; p.qz = 0; pending_pairs.push_back(p);
    p.qw = 11585; p.qx = 0; p.qy = 11585; p.qz = 0; p.bx = 0; p.by = 0; p.bz = 0;
    p.sx = 3000; p.sy = -1000; p.sz = 500; p.rad = 8192;
    p.half = {20'd8192, 20'd4096, 20'd2048}; pending_pairs.push_back(p);
    for (int i = 0; i < 8; i++) pending_pairs.push_back(random_pair(1 + i % 2));
    wait_drained();

    // Several threshold settings, each with its share of random pairs.
    for (int ph = 0; ph < 5; ph++) begin
      write_threshold(settings[ph]);
      for (int i = 0; i < NUM_RANDOM / 5; i++) begin
        int k;
        k = $urandom_range(0, 9);
        pending_pairs.push_back(random_pair(k == 0 ? 0 : (k < 5 ? 1 : 2)));
      end
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering.
        while (pairs_sent < 50) @(posedge clk);
        stall_long = 1'b1;
        repeat (300) @(posedge clk);
        stall_long = 1'b0;
      end
      wait_drained();
    end

    $display("Covered %0d pairs, %0d contacts (%0d hits) over five inside thresholds,",
             pairs_sent, contacts_seen, hits_seen);
    $display("with sender bursts, receiver stalls and one long output hold-off.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
